// File: src/moc_pkg.sv
package moc_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC_HIT  = 2'd0;
  localparam logic [1:0] ST_ALLOC_MISS = 2'd1;
  localparam logic [1:0] ST_FREE_OK    = 2'd2;
  localparam logic [1:0] ST_FREE_OVF   = 2'd3;

  localparam logic REGION_FULL  = 1'b0;
  localparam logic REGION_EMPTY = 1'b1;

  localparam int CFG_BITS = 5;

endpackage

// File: src/magazine_object_cache_core.sv
// The result strobe comes in the cycle after acceptance for an alloc miss, a free absorbed into
// the loaded or previous magazine, and a free overflow. An alloc hit on the loaded or previous
// magazine waits on a registered read of the round store, a free that trades with the depot on a
// registered read of the depot memory, and an alloc that trades on both, depot memory first.
// A new command is taken in the cycle the result is shown.
// Synchronous reset clears control state; no clearing pass. The receiver cannot stall.
module magazine_object_cache_core import moc_pkg::*; #(
  parameter int MAG_MAX   = 16,
  parameter int NUM_MAGS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [ADDR_BITS-1:0] obj_addr,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_BITS-1:0] addr,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  localparam int MB   = $clog2(NUM_MAGS);
  localparam int CB   = $clog2(MAG_MAX + 1);
  localparam int DB   = $clog2(NUM_MAGS + 1);
  localparam int RB   = $clog2(NUM_MAGS * MAG_MAX);
  localparam int CMPW = (CB > CFG_BITS) ? CB : CFG_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_TRADE_ALLOC,
    S_TRADE_FREE
  } state_t;

  state_t                state;
  logic [MB-1:0]         loaded;
  logic [MB-1:0]         prev;
  logic [CB-1:0]         lcnt;
  logic [CB-1:0]         pcnt;
  logic [DB-1:0]         fdep;
  logic [DB-1:0]         edep;
  logic [CFG_BITS-1:0]   mag_size;
  logic [ADDR_BITS-1:0]  buf_q;

  logic                  rs_we;
  logic [RB-1:0]         rs_waddr;
  logic [ADDR_BITS-1:0]  rs_wdata;
  logic [RB-1:0]         rs_raddr;
  logic [ADDR_BITS-1:0]  rs_rdata;
  logic                  dp_we;
  logic [MB:0]           dp_waddr;
  logic [MB+CB-1:0]      dp_wdata;
  logic [MB:0]           dp_raddr;
  logic [MB+CB-1:0]      dp_rdata;
  logic [MB-1:0]         dp_mag;
  logic [CB-1:0]         dp_cnt;

  logic                  accept;
  logic [CMPW-1:0]       size_ext;
  logic [CB-1:0]         tgt;
  logic                  tgt_nz;
  logic                  l_nz;
  logic                  p_nz;
  logic                  f_nz;
  logic                  e_nz;
  logic                  l_room;
  logic                  p_room;
  logic [DB-1:0]         fdep_m1;
  logic [DB-1:0]         edep_m1;

  function automatic logic [RB-1:0] ridx(input logic [MB-1:0] m, input logic [CB-1:0] c);
    return RB'(RB'(m) * RB'(MAG_MAX)) + RB'(c);
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign size_ext = CMPW'(mag_size);
  assign tgt      = (size_ext > CMPW'(MAG_MAX)) ? CB'(MAG_MAX) : CB'(size_ext);
  assign tgt_nz   = (tgt != '0);
  assign l_nz     = (lcnt != '0);
  assign p_nz     = (pcnt != '0);
  assign f_nz     = (fdep != '0);
  assign e_nz     = (edep != '0);
  assign l_room   = (lcnt < tgt);
  assign p_room   = (pcnt < tgt);
  assign fdep_m1  = fdep - DB'(1);
  assign edep_m1  = edep - DB'(1);
  assign dp_mag   = dp_rdata[MB+CB-1:CB];
  assign dp_cnt   = dp_rdata[CB-1:0];

  always_comb begin
    rs_we    = 1'b0;
    rs_waddr = '0;
    rs_wdata = obj_addr;
    rs_raddr = '0;
    dp_we    = 1'b0;
    dp_waddr = '0;
    dp_wdata = '0;
    dp_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_ALLOC) begin
          if (l_nz) begin
            rs_raddr = ridx(loaded, lcnt - CB'(1));
          end else if (p_nz) begin
            rs_raddr = ridx(prev, pcnt - CB'(1));
          end else if (f_nz) begin
            dp_raddr = {REGION_FULL, fdep_m1[MB-1:0]};
            dp_we    = 1'b1;
            dp_waddr = {REGION_EMPTY, edep[MB-1:0]};
            dp_wdata = {prev, CB'(0)};
          end
        end else if (accept && tgt_nz) begin
          if (l_room) begin
            rs_we    = 1'b1;
            rs_waddr = ridx(loaded, lcnt);
          end else if (p_room) begin
            rs_we    = 1'b1;
            rs_waddr = ridx(prev, pcnt);
          end else if (e_nz) begin
            dp_raddr = {REGION_EMPTY, edep_m1[MB-1:0]};
            dp_we    = 1'b1;
            dp_waddr = {REGION_FULL, fdep[MB-1:0]};
            dp_wdata = {prev, pcnt};
          end
        end
      end
      S_TRADE_ALLOC: begin
        rs_raddr = ridx(dp_mag, dp_cnt - CB'(1));
      end
      S_TRADE_FREE: begin
        rs_we    = 1'b1;
        rs_waddr = ridx(dp_mag, CB'(0));
        rs_wdata = buf_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      status   <= ST_ALLOC_HIT;
      addr     <= '0;
      loaded   <= MB'(0);
      prev     <= MB'(1);
      lcnt     <= '0;
      pcnt     <= '0;
      fdep     <= '0;
      edep     <= DB'(NUM_MAGS - 2);
      mag_size <= CFG_BITS'(1);
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mag_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            buf_q <= obj_addr;
            if (cmd == CMD_ALLOC) begin
              if (l_nz) begin
                lcnt  <= lcnt - CB'(1);
                state <= S_POP;
              end else if (p_nz) begin
                loaded <= prev;
                prev   <= loaded;
                lcnt   <= pcnt - CB'(1);
                pcnt   <= lcnt;
                state  <= S_POP;
              end else if (f_nz) begin
                fdep  <= fdep_m1;
                edep  <= edep + DB'(1);
                prev  <= loaded;
                pcnt  <= lcnt;
                state <= S_TRADE_ALLOC;
              end else begin
                done   <= 1'b1;
                status <= ST_ALLOC_MISS;
                addr   <= '0;
              end
            end else begin
              if (tgt_nz && l_room) begin
                lcnt   <= lcnt + CB'(1);
                done   <= 1'b1;
                status <= ST_FREE_OK;
                addr   <= '0;
              end else if (tgt_nz && p_room) begin
                loaded <= prev;
                prev   <= loaded;
                lcnt   <= pcnt + CB'(1);
                pcnt   <= lcnt;
                done   <= 1'b1;
                status <= ST_FREE_OK;
                addr   <= '0;
              end else if (tgt_nz && e_nz) begin
                edep  <= edep_m1;
                fdep  <= fdep + DB'(1);
                prev  <= loaded;
                pcnt  <= lcnt;
                state <= S_TRADE_FREE;
              end else begin
                done   <= 1'b1;
                status <= ST_FREE_OVF;
                addr   <= obj_addr;
              end
            end
          end
        end
        S_POP: begin
          done   <= 1'b1;
          status <= ST_ALLOC_HIT;
          addr   <= rs_rdata;
          state  <= S_IDLE;
        end
        S_TRADE_ALLOC: begin
          loaded <= dp_mag;
          lcnt   <= dp_cnt - CB'(1);
          state  <= S_POP;
        end
        S_TRADE_FREE: begin
          loaded <= dp_mag;
          lcnt   <= CB'(1);
          done   <= 1'b1;
          status <= ST_FREE_OK;
          addr   <= '0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  moc_round_mem #(
    .DEPTH (NUM_MAGS * MAG_MAX),
    .WIDTH (ADDR_BITS)
  ) u_round_mem (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  moc_depot_mem #(
    .NUM_MAGS (NUM_MAGS),
    .CNT_BITS (CB)
  ) u_depot_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (dp_wdata),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  // Every magazine sits in exactly one place.
  a_mag_conservation: assert property (@(posedge clk) disable iff (rst)
    ((DB+1)'(fdep) + (DB+1)'(edep) + (DB+1)'(2)) == (DB+1)'(NUM_MAGS))
    else $error("Depot depths do not account for every magazine.");

  a_distinct_mags: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (loaded != prev))
    else $error("Loaded and previous magazine are the same.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (lcnt <= CB'(MAG_MAX)) && (pcnt <= CB'(MAG_MAX)))
    else $error("Magazine round count exceeds its capacity.");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("Accepted transfer neither progressed nor completed.");

endmodule

// File: src/moc_round_mem.sv
module moc_round_mem import moc_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/moc_depot_mem.sv
module moc_depot_mem import moc_pkg::*; #(
  parameter int NUM_MAGS = 16,
  parameter int CNT_BITS = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   we,
  input  logic [$clog2(NUM_MAGS):0]              waddr,
  input  logic [$clog2(NUM_MAGS)+CNT_BITS-1:0]   wdata,
  input  logic [$clog2(NUM_MAGS):0]              raddr,
  output logic [$clog2(NUM_MAGS)+CNT_BITS-1:0]   rdata
);

  localparam int MB = $clog2(NUM_MAGS);
  localparam int DW = MB + CNT_BITS;

  logic [DW-1:0]       mem [2**(MB+1)];
  logic [NUM_MAGS-1:0] empty_written;
  logic [DW-1:0]       mem_rdata;
  logic                rd_initial;
  logic [MB-1:0]       rd_idx;

  // Entries of the empty stack that were never written hold their reset magazine.
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_written <= '0;
    end else if (we && waddr[MB] == REGION_EMPTY) begin
      empty_written[waddr[MB-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_rdata  <= mem[raddr];
    rd_initial <= (raddr[MB] == REGION_EMPTY) && !empty_written[raddr[MB-1:0]];
    rd_idx     <= raddr[MB-1:0];
  end

  assign rdata = rd_initial ? {MB'(rd_idx + MB'(2)), CNT_BITS'(0)} : mem_rdata;

endmodule

// File: bench/tb_magazine_object_cache_core.sv
module tb_magazine_object_cache_core;
  import moc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAG_MAX   = 16;
  localparam int NUM_MAGS  = 16;
  localparam int ADDR_BITS = 32;
  localparam int SETTLE    = 4;
  localparam int N_RANDOM  = 1300;

  typedef struct {
    logic                 is_cfg;
    logic                 cmd;
    logic [ADDR_BITS-1:0] baddr;
    logic [CFG_BITS-1:0]  value;
  } request_t;

  typedef struct {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] addr;
  } reply_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 cmd       = CMD_ALLOC;
  logic [ADDR_BITS-1:0] obj_addr  = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data  = '0;
  logic                 busy;
  logic                 done;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] addr;
  logic                 cfg_ready;

  request_t request_q[$];
  reply_t   reply_q[$];

  logic [ADDR_BITS-1:0] rounds[NUM_MAGS*MAG_MAX];
  logic [4:0]           fill[NUM_MAGS];
  logic [3:0]           loaded_m;
  logic [3:0]           prev_m;
  logic [3:0]           full_mags[NUM_MAGS];
  logic [4:0]           full_top;
  logic [3:0]           empty_mags[NUM_MAGS];
  logic [4:0]           empty_top;
  logic [CFG_BITS-1:0]  fill_target;

  int errors    = 0;
  int n_hit     = 0;
  int n_miss    = 0;
  int n_absorb  = 0;
  int n_ovf     = 0;
  int n_cfg     = 0;
  int gap       = 0;
  int burst     = 0;
  int quiet     = 0;

  magazine_object_cache_core #(
    .MAG_MAX  (MAG_MAX),
    .NUM_MAGS (NUM_MAGS),
    .ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .obj_addr (obj_addr),
    .done     (done),
    .status   (status),
    .addr     (addr),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic reset_cache();
    for (int i = 0; i < NUM_MAGS*MAG_MAX; i++) rounds[i] = '0;
    for (int i = 0; i < NUM_MAGS; i++) begin
      fill[i]       = '0;
      full_mags[i]  = '0;
      empty_mags[i] = '0;
    end
    loaded_m  = 4'd0;
    prev_m    = 4'd1;
    full_top  = '0;
    empty_top = '0;
    for (int i = 2; i < NUM_MAGS; i++) begin
      empty_mags[empty_top] = 4'(i);
      empty_top++;
    end
    fill_target = 5'd1;
  endtask

  // The outgoing previous magazine goes back to whichever depot stack suits its contents.
  task automatic park_magazine(input logic [3:0] m);
    if (fill[m] != 0) begin
      if (full_top < NUM_MAGS) begin
        full_mags[full_top] = m;
        full_top++;
      end
    end else if (empty_top < NUM_MAGS) begin
      empty_mags[empty_top] = m;
      empty_top++;
    end
  endtask

  task automatic cache_request(input logic c, input logic [ADDR_BITS-1:0] a,
                               output reply_t r);
    logic [4:0] tgt;
    logic [4:0] n;
    logic [3:0] m;
    logic [3:0] t;
    logic       room;
    r.status = ST_ALLOC_MISS;
    r.addr   = '0;
    if (c == CMD_ALLOC) begin
      if (fill[loaded_m] == 0) begin
        if (fill[prev_m] != 0) begin
          t = prev_m;
          prev_m = loaded_m;
          loaded_m = t;
        end else if (full_top != 0) begin
          full_top--;
          m = full_mags[full_top];
          park_magazine(prev_m);
          prev_m = loaded_m;
          loaded_m = m;
        end
      end
      n = fill[loaded_m];
      if (n != 0 && n <= MAG_MAX) begin
        n--;
        fill[loaded_m] = n;
        r.status = ST_ALLOC_HIT;
        r.addr   = rounds[int'(loaded_m)*MAG_MAX + int'(n)];
      end
    end else begin
      tgt  = (fill_target > MAG_MAX) ? 5'(MAG_MAX) : fill_target;
      room = 1'b0;
      if (tgt != 0) begin
        if (fill[loaded_m] < tgt) begin
          room = 1'b1;
        end else if (fill[prev_m] < tgt) begin
          t = prev_m;
          prev_m = loaded_m;
          loaded_m = t;
          room = 1'b1;
        end else if (empty_top != 0) begin
          empty_top--;
          m = empty_mags[empty_top];
          park_magazine(prev_m);
          prev_m = loaded_m;
          loaded_m = m;
          room = fill[m] < tgt;
        end
      end
      if (!room) begin
        r.status = ST_FREE_OVF;
        r.addr   = a;
      end else begin
        n = fill[loaded_m];
        rounds[int'(loaded_m)*MAG_MAX + int'(n)] = a;
        fill[loaded_m] = n + 5'd1;
        r.status = ST_FREE_OK;
      end
    end
  endtask

  task automatic add_cfg(input logic [CFG_BITS-1:0] v);
    request_t q;
    q.is_cfg = 1'b1;
    q.cmd    = CMD_ALLOC;
    q.baddr  = '0;
    q.value  = v;
    request_q.push_back(q);
  endtask

  task automatic add_req(input logic c, input logic [ADDR_BITS-1:0] a);
    request_t q;
    q.is_cfg = 1'b0;
    q.cmd    = c;
    q.baddr  = a;
    q.value  = '0;
    request_q.push_back(q);
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_addr();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : drive
    logic next_start;
    logic next_cfg;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      quiet     <= 0;
    end else begin
      if (!start && !cfg_valid && !busy && !done && reply_q.size() == 0) quiet <= quiet + 1;
      else quiet <= 0;
      if (!((start && busy) || (cfg_valid && !cfg_ready))) begin
        next_start = 1'b0;
        next_cfg   = 1'b0;
        if (request_q.size() != 0) begin
          if (request_q[0].is_cfg) begin
            if (quiet >= SETTLE) begin
              next_cfg = 1'b1;
              cfg_data <= request_q[0].value;
              void'(request_q.pop_front());
            end
          end else if (gap != 0) begin
            gap <= gap - 1;
          end else begin
            next_start = 1'b1;
            cmd      <= request_q[0].cmd;
            obj_addr <= request_q[0].baddr;
            void'(request_q.pop_front());
            if (burst == 0) begin
              burst <= $urandom_range(0, 15);
              gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
              burst <= burst - 1;
            end
          end
        end
        start     <= next_start;
        cfg_valid <= next_cfg;
      end
    end
  end

  always @(posedge clk) begin : watch
    reply_t expd;
    reply_t got;
    if (rst) begin
      reset_cache();
    end else begin
      if (done) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d, addr %h",
                   $time, status, addr);
          errors++;
        end else begin
          expd = reply_q.pop_front();
          if (status !== expd.status) begin
            $display("%0t: status expected %0d, got %0d", $time, expd.status, status);
            errors++;
          end
          if (addr !== expd.addr) begin
            $display("%0t: addr expected %h, got %h", $time, expd.addr, addr);
            errors++;
          end
        end
        case (status)
          ST_ALLOC_HIT:  n_hit++;
          ST_ALLOC_MISS: n_miss++;
          ST_FREE_OK:    n_absorb++;
          default:       n_ovf++;
        endcase
      end
      if (start && !busy) begin
        cache_request(cmd, obj_addr, got);
        reply_q.push_back(got);
      end
      if (cfg_valid && cfg_ready) begin
        fill_target = cfg_data;
        n_cfg++;
      end
    end
  end

  initial begin
    int n_items;
    int len;
    int free_pct;

    // Directed part at the reset fill target of one.
    add_req(CMD_ALLOC, 32'h1111_1111);
    add_req(CMD_FREE,  32'hFFFF_FFFF);
    add_req(CMD_FREE,  32'h0000_0000);
    add_req(CMD_FREE,  32'h1234_5678);
    add_req(CMD_FREE,  32'h9ABC_DEF0);
    for (int i = 0; i < 5; i++) add_req(CMD_ALLOC, 32'hFFFF_FFFF);
    add_cfg(5'd0);
    add_req(CMD_FREE,  32'hDEAD_BEEF);
    add_req(CMD_ALLOC, 32'h0);
    add_cfg(5'd31);
    for (int i = 0; i < 6; i++) add_req(CMD_FREE, 32'hA5A5_0000 + 32'(i));
    add_req(CMD_ALLOC, 32'h0);
    add_cfg(5'd2);
    add_req(CMD_FREE,  32'h5A5A_5A5A);
    add_req(CMD_ALLOC, 32'h0);
    add_cfg(5'd16);

    // Random phases, each with its own fill target and its own mix of frees.
    n_items = 0;
    while (n_items < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0:       add_cfg(5'd0);
        1:       add_cfg(5'd16);
        2:       add_cfg(5'd1);
        3:       add_cfg(5'($urandom_range(17, 31)));
        default: add_cfg(5'($urandom_range(1, 16)));
      endcase
      case ($urandom_range(0, 3))
        0:       free_pct = 15;
        1:       free_pct = 50;
        2:       free_pct = 85;
        default: free_pct = 97;
      endcase
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        add_req(($urandom_range(1, 100) <= free_pct) ? CMD_FREE : CMD_ALLOC, pick_addr());
      end
      n_items += len;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (request_q.size() != 0 || start || cfg_valid || reply_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, reply_q.size());
    end
    $display("Covered %0d register writes and %0d requests.", n_cfg,
             n_hit + n_miss + n_absorb + n_ovf);
    $display("Alloc hits %0d, misses %0d; frees absorbed %0d, overflowed %0d.",
             n_hit, n_miss, n_absorb, n_ovf);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb_magazine_object_cache_core: done, clean");
    end else begin
      $display("tb_magazine_object_cache_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_magazine_object_cache_core: done, errors");
    $finish;
  end

endmodule

// File: magazine_object_cache_core.f
src/moc_pkg.sv
src/moc_round_mem.sv
src/moc_depot_mem.sv
src/magazine_object_cache_core.sv
bench/tb_magazine_object_cache_core.sv
